/* src/rgbpal_pkg.sv */
`default_nettype none
package rgbpal_pkg;

  localparam int TABLE_SLOTS         = 293;
  localparam int FIRST_DYNAMIC_INDEX = 64;
  localparam int INDEX_LIMIT         = 256;
  localparam int OFF_CUBE            = 8'h80;

  localparam int CH5_W    = 5;
  localparam int CH6_W    = 6;
  localparam int KEY_W    = 3 * CH5_W;
  localparam int IDX_W    = 8;
  localparam int NFREE_W  = 9;
  localparam int ENTRY_W  = KEY_W + IDX_W;
  localparam int SLOT_W   = $clog2(TABLE_SLOTS);

  // key mod TABLE_SLOTS by reciprocal multiply, then one compare and subtract
  localparam int RECIP_SHIFT = 23;
  localparam int RECIP       = (1 << RECIP_SHIFT) / TABLE_SLOTS;
  localparam int RECIP_W     = $clog2(RECIP + 1);
  localparam int PROD_W      = KEY_W + RECIP_W;
  localparam int Q_W         = $clog2((1 << KEY_W) / TABLE_SLOTS + 1);
  localparam int REM_W       = SLOT_W + 1;

  localparam int FIFO_DEPTH = 2;
  localparam int FPTR_W     = $clog2(FIFO_DEPTH);
  localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic              cube_hit;
    logic [5:0]        cube_idx;
    logic [KEY_W-1:0]  key;
    logic [SLOT_W-1:0] slot;
    logic [CH6_W-1:0]  pal_red;
    logic [CH6_W-1:0]  pal_green;
    logic [CH6_W-1:0]  pal_blue;
  } item_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PROBE,
    ST_EMIT
  } back_state_t;

  // 2-bit level code per channel on the fixed cube, off-cube marker otherwise
  function automatic logic [7:0] cube_code(input logic [CH5_W-1:0] c);
    logic [7:0] code;
    unique case (c)
      5'd0:    code = 8'd0;
      5'd10:   code = 8'd8;
      5'd21:   code = 8'd1;
      5'd31:   code = 8'd9;
      default: code = 8'(OFF_CUBE);
    endcase
    return code;
  endfunction

endpackage
`default_nettype wire

/* src/rgbpal_ram.sv */
`default_nettype none
module rgbpal_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

/* src/rgbpal_front.sv */
`default_nettype none
module rgbpal_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire logic [15:0]         in_red,
  input  wire logic [15:0]         in_green,
  input  wire logic [15:0]         in_blue,
  output logic                     in_stall,
  input  wire logic                clearing,
  input  wire logic                fifo_full,
  output logic                     push,
  output rgbpal_pkg::item_t        push_item
);
  import rgbpal_pkg::*;

  logic               accept;
  logic [CH5_W-1:0]   r5, g5, b5;
  logic [KEY_W-1:0]   key_in;
  logic [7:0]         cr, cg, cb;
  logic [10:0]        cx;
  logic [PROD_W-1:0]  prod;

  logic               s1_valid_r, s1_valid_nxt;
  logic [KEY_W-1:0]   s1_key_r;
  logic [Q_W-1:0]     s1_q_r;
  logic               s1_hit_r;
  logic [5:0]         s1_idx_r;
  logic [CH6_W-1:0]   s1_r6_r, s1_g6_r, s1_b6_r;

  logic [KEY_W-1:0]   diff;
  logic [REM_W-1:0]   rem;
  logic [SLOT_W-1:0]  slot;

  assign in_stall = clearing || (s1_valid_r && fifo_full);
  assign accept   = in_valid && !in_stall;

  assign r5     = in_red[15:11];
  assign g5     = in_green[15:11];
  assign b5     = in_blue[15:11];
  assign key_in = {r5, g5, b5};
  assign cr     = cube_code(r5);
  assign cg     = cube_code(g5);
  assign cb     = cube_code(b5);
  assign cx     = {1'b0, cr, 2'b00} + {2'b00, cg, 1'b0} + {3'b000, cb};
  assign prod   = PROD_W'(key_in) * PROD_W'(RECIP);

  // quotient estimate is low by at most one, so remainder stays below 2x slots
  assign diff = s1_key_r - (KEY_W'(s1_q_r) * KEY_W'(TABLE_SLOTS));
  assign rem  = diff[REM_W-1:0];
  assign slot = (rem >= REM_W'(TABLE_SLOTS)) ? SLOT_W'(rem - REM_W'(TABLE_SLOTS))
                                             : SLOT_W'(rem);

  assign push = s1_valid_r && !fifo_full;

  always_comb begin
    push_item.cube_hit  = s1_hit_r;
    push_item.cube_idx  = s1_idx_r;
    push_item.key       = s1_key_r;
    push_item.slot      = slot;
    push_item.pal_red   = s1_r6_r;
    push_item.pal_green = s1_g6_r;
    push_item.pal_blue  = s1_b6_r;
  end

  assign s1_valid_nxt = accept || (s1_valid_r && !push);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_key_r <= key_in;
      s1_q_r   <= prod[RECIP_SHIFT +: Q_W];
      s1_hit_r <= (cx[10:6] == 5'd0);
      s1_idx_r <= cx[5:0];
      s1_r6_r  <= in_red[15:10];
      s1_g6_r  <= in_green[15:10];
      s1_b6_r  <= in_blue[15:10];
    end
  end

endmodule
`default_nettype wire

/* src/rgbpal_fifo.sv */
`default_nettype none
module rgbpal_fifo (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire rgbpal_pkg::item_t push_item,
  output logic              full,
  input  wire logic         pop,
  output logic              empty,
  output rgbpal_pkg::item_t head
);
  import rgbpal_pkg::*;

  item_t             mem_r [FIFO_DEPTH];
  logic [FPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [FCNT_W-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == FCNT_W'(FIFO_DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + FCNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - FCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + FPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + FPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule
`default_nettype wire

/* src/rgbpal_back.sv */
`default_nettype none
module rgbpal_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                empty,
  input  wire rgbpal_pkg::item_t   head,
  output logic                     pop,
  output logic                     clearing,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [7:0]               out_color_index,
  output logic                     out_no_color,
  output logic                     out_palette_write,
  output logic [5:0]               out_palette_red,
  output logic [5:0]               out_palette_green,
  output logic [5:0]               out_palette_blue
);
  import rgbpal_pkg::*;

  back_state_t         state_r, state_nxt;
  logic [SLOT_W-1:0]   clr_r, clr_nxt;
  logic [SLOT_W-1:0]   slot_r, slot_nxt, slot_inc;
  logic [SLOT_W-1:0]   cnt_r, cnt_nxt;
  logic [NFREE_W-1:0]  nfree_r, nfree_nxt;
  item_t               cur_r, cur_nxt;

  logic [IDX_W-1:0]    res_idx_r, res_idx_nxt;
  logic                res_none_r, res_none_nxt;
  logic                res_wr_r, res_wr_nxt;
  logic [CH6_W-1:0]    res_r6_r, res_r6_nxt;
  logic [CH6_W-1:0]    res_g6_r, res_g6_nxt;
  logic [CH6_W-1:0]    res_b6_r, res_b6_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic                out_load;
  logic                out_free;

  logic                ram_we;
  logic [SLOT_W-1:0]   ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0]  ram_wdata, ram_rdata;
  logic [KEY_W-1:0]    ent_key;

  rgbpal_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_SLOTS)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  assign clearing = (state_r == ST_CLEAR);
  assign out_free = !out_valid_r || !out_stall;
  assign ent_key  = ram_rdata[ENTRY_W-1:IDX_W];
  assign slot_inc = (slot_r == SLOT_W'(TABLE_SLOTS - 1)) ? '0 : slot_r + SLOT_W'(1);

  always_comb begin
    state_nxt    = state_r;
    clr_nxt      = clr_r;
    slot_nxt     = slot_r;
    cnt_nxt      = cnt_r;
    nfree_nxt    = nfree_r;
    cur_nxt      = cur_r;
    res_idx_nxt  = res_idx_r;
    res_none_nxt = res_none_r;
    res_wr_nxt   = res_wr_r;
    res_r6_nxt   = res_r6_r;
    res_g6_nxt   = res_g6_r;
    res_b6_nxt   = res_b6_r;
    pop          = 1'b0;
    out_load     = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = slot_r;
    ram_wdata    = {cur_r.key, nfree_r[IDX_W-1:0]};
    ram_raddr    = slot_r;

    unique case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
        clr_nxt   = clr_r + SLOT_W'(1);
        if (clr_r == SLOT_W'(TABLE_SLOTS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        ram_raddr = head.slot;
        if (!empty) begin
          pop          = 1'b1;
          cur_nxt      = head;
          slot_nxt     = head.slot;
          cnt_nxt      = '0;
          res_idx_nxt  = {2'b00, head.cube_idx};
          res_none_nxt = 1'b0;
          res_wr_nxt   = 1'b0;
          res_r6_nxt   = '0;
          res_g6_nxt   = '0;
          res_b6_nxt   = '0;
          state_nxt    = head.cube_hit ? ST_EMIT : ST_PROBE;
        end
      end

      ST_PROBE: begin
        if (ent_key == '0) begin
          // empty slot: claim the next dynamic index if any is left
          state_nxt = ST_EMIT;
          if (nfree_r < NFREE_W'(INDEX_LIMIT)) begin
            ram_we      = 1'b1;
            res_idx_nxt = nfree_r[IDX_W-1:0];
            res_wr_nxt  = 1'b1;
            res_r6_nxt  = cur_r.pal_red;
            res_g6_nxt  = cur_r.pal_green;
            res_b6_nxt  = cur_r.pal_blue;
            nfree_nxt   = nfree_r + NFREE_W'(1);
          end else begin
            res_idx_nxt  = '0;
            res_none_nxt = 1'b1;
          end
        end else if (ent_key == cur_r.key) begin
          res_idx_nxt = ram_rdata[IDX_W-1:0];
          state_nxt   = ST_EMIT;
        end else if (cnt_r == SLOT_W'(TABLE_SLOTS - 1)) begin
          res_idx_nxt  = '0;
          res_none_nxt = 1'b1;
          state_nxt    = ST_EMIT;
        end else begin
          slot_nxt  = slot_inc;
          cnt_nxt   = cnt_r + SLOT_W'(1);
          ram_raddr = slot_inc;
        end
      end

      ST_EMIT: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      nfree_r     <= NFREE_W'(FIRST_DYNAMIC_INDEX);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      nfree_r     <= nfree_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r     <= slot_nxt;
    cnt_r      <= cnt_nxt;
    cur_r      <= cur_nxt;
    res_idx_r  <= res_idx_nxt;
    res_none_r <= res_none_nxt;
    res_wr_r   <= res_wr_nxt;
    res_r6_r   <= res_r6_nxt;
    res_g6_r   <= res_g6_nxt;
    res_b6_r   <= res_b6_nxt;
    if (out_load) begin
      out_color_index   <= res_idx_r;
      out_no_color      <= res_none_r;
      out_palette_write <= res_wr_r;
      out_palette_red   <= res_r6_r;
      out_palette_green <= res_g6_r;
      out_palette_blue  <= res_b6_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

/* src/rgb_palette_index_allocator.sv */
// rgb_palette_index_allocator: maps 16-bit rgb requests to 8-bit palette indices
// input channel: in_valid / in_stall with in_red, in_green, in_blue; an item is
//   taken at a clock edge with in_valid high and in_stall low
// result channel: out_valid / out_stall with the index, no_color flag and a
//   palette write (6-bit channels) whenever a new dynamic index is handed out
// colors on the fixed 4-level cube get a fixed index below 64 without a lookup;
//   other colors probe a 293-slot linear-probing table, one slot per cycle
// an accepted item goes through the front register, the queue, the probe engine
//   and the output register; other colors add one probe step per slot read
// the probe engine works on one item at a time and pops the next one only
//   after the current result has been loaded into the output register
// reset (synchronous, rst_n low) starts a clearing pass over all 293 slots of the
//   table; in_stall stays high until it is done, and the next free index is 64
// a stalled result holds in the output register while the front stage and the
//   2-entry queue keep taking items; in_stall rises only when those are full
`default_nettype none
module rgb_palette_index_allocator (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [15:0] in_red,
  input  wire logic [15:0] in_green,
  input  wire logic [15:0] in_blue,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_color_index,
  output logic             out_no_color,
  output logic             out_palette_write,
  output logic [5:0]       out_palette_red,
  output logic [5:0]       out_palette_green,
  output logic [5:0]       out_palette_blue
);
  import rgbpal_pkg::*;

  // front to queue
  logic  push;
  item_t push_item;
  logic  fifo_full;

  // queue to probe engine
  logic  pop;
  logic  fifo_empty;
  item_t head;

  // table clearing pass holds off new items
  logic  clearing;

  // front: cube check, color key and start slot (key mod table size)
  rgbpal_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_red    (in_red),
    .in_green  (in_green),
    .in_blue   (in_blue),
    .in_stall  (in_stall),
    .clearing  (clearing),
    .fifo_full (fifo_full),
    .push      (push),
    .push_item (push_item)
  );

  // short queue decouples classification from probing
  rgbpal_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (fifo_full),
    .pop       (pop),
    .empty     (fifo_empty),
    .head      (head)
  );

  // back: table probe, index allocation and output register
  rgbpal_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .empty             (fifo_empty),
    .head              (head),
    .pop               (pop),
    .clearing          (clearing),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_color_index   (out_color_index),
    .out_no_color      (out_no_color),
    .out_palette_write (out_palette_write),
    .out_palette_red   (out_palette_red),
    .out_palette_green (out_palette_green),
    .out_palette_blue  (out_palette_blue)
  );

endmodule
`default_nettype wire

/* dv/rgb_palette_index_allocator_tb.sv */
`timescale 1ns / 100ps
module rgb_palette_index_allocator_tb;
  import rgbpal_pkg::*;

  // one color request as it goes onto the input channel
  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
  } color_request_t;

  // one answer from the block, same fields as the result channel
  typedef struct packed {
    logic [IDX_W-1:0] color_index;
    logic             no_color;
    logic             palette_write;
    logic [CH6_W-1:0] palette_red;
    logic [CH6_W-1:0] palette_green;
    logic [CH6_W-1:0] palette_blue;
  } color_result_t;

  // clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  always #10 clk = ~clk;

  // block inputs, all known from time zero
  logic        in_valid  = 1'b0;
  logic [15:0] in_red    = '0;
  logic [15:0] in_green  = '0;
  logic [15:0] in_blue   = '0;
  logic        out_stall = 1'b0;

  // block outputs
  logic       in_stall;
  logic       out_valid;
  logic [7:0] out_color_index;
  logic       out_no_color;
  logic       out_palette_write;
  logic [5:0] out_palette_red;
  logic [5:0] out_palette_green;
  logic [5:0] out_palette_blue;

  rgb_palette_index_allocator u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_red            (in_red),
    .in_green          (in_green),
    .in_blue           (in_blue),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_color_index   (out_color_index),
    .out_no_color      (out_no_color),
    .out_palette_write (out_palette_write),
    .out_palette_red   (out_palette_red),
    .out_palette_green (out_palette_green),
    .out_palette_blue  (out_palette_blue)
  );

  // requests waiting to be driven, answers waiting to come out
  color_request_t   pending_colors[$];
  color_result_t    expected_answers[$];
  logic [KEY_W-1:0] requested_keys[$];   // keys already asked for, reused for hits
  int               mismatch_count = 0;
  int               total_items    = 0;
  int               answered_count = 0;

  // private copy of the lookup table and the allocation counter
  logic [KEY_W-1:0]   shadow_key[TABLE_SLOTS];
  logic [IDX_W-1:0]   shadow_index[TABLE_SLOTS];
  logic [NFREE_W-1:0] shadow_next_free;

  // the four channel levels of the fixed cube
  logic [CH5_W-1:0] cube_levels[4] = '{5'd0, 5'd10, 5'd21, 5'd31};

  // idle control; idle_allowed is shared by both sides
  logic idle_allowed = 1'b0;
  int   calm_left    = 0;
  int   gap_left     = 0;
  int   stall_left   = 0;

  // {on cube, high bit, low bit} for one 5-bit channel
  function automatic logic [2:0] cube_pair(input logic [CH5_W-1:0] c5);
    case (c5)
      5'd0:    return 3'b100;
      5'd10:   return 3'b110;
      5'd21:   return 3'b101;
      5'd31:   return 3'b111;
      default: return 3'b000;
    endcase
  endfunction

  // index mapping with table update, one call per accepted request
  function automatic color_result_t map_color(input logic [15:0] r, g, b);
    color_result_t    res;
    logic [2:0]       pr, pg, pb;
    logic [KEY_W-1:0] key;
    int               slot;
    int               probes;
    logic             hunting;
    res = '0;
    pr  = cube_pair(r[15:11]);
    pg  = cube_pair(g[15:11]);
    pb  = cube_pair(b[15:11]);
    // fixed cube: red, green, blue high bits in 5..3, low bits in 2..0
    if (pr[2] && pg[2] && pb[2]) begin
      res.color_index = {2'b00, pr[1], pg[1], pb[1], pr[0], pg[0], pb[0]};
      return res;
    end
    key     = {r[15:11], g[15:11], b[15:11]};
    slot    = key % TABLE_SLOTS;
    probes  = 0;
    hunting = 1'b1;
    // linear probe with wrap, bounded to one pass over the table
    while (hunting && probes < TABLE_SLOTS) begin
      if (shadow_key[slot] == '0) begin
        hunting = 1'b0;
      end else if (shadow_key[slot] == key) begin
        res.color_index = shadow_index[slot];
        return res;
      end else begin
        slot   = (slot == TABLE_SLOTS - 1) ? 0 : slot + 1;
        probes = probes + 1;
      end
    end
    // palette exhausted or no empty slot: report no color
    if (hunting || shadow_next_free >= INDEX_LIMIT) begin
      res.no_color = 1'b1;
      return res;
    end
    res.color_index    = shadow_next_free[IDX_W-1:0];
    res.palette_write  = 1'b1;
    res.palette_red    = r[15:10];
    res.palette_green  = g[15:10];
    res.palette_blue   = b[15:10];
    shadow_key[slot]   = key;
    shadow_index[slot] = shadow_next_free[IDX_W-1:0];
    shadow_next_free   = shadow_next_free + 1'b1;
    return res;
  endfunction

  // 16-bit channel with the given top 5 bits and random low bits
  function automatic logic [15:0] spread(input logic [CH5_W-1:0] c5);
    logic [10:0] low;
    low = $urandom;
    return {c5, low};
  endfunction

  task automatic queue_color(input logic [15:0] r, g, b);
    color_request_t req;
    req.red   = r;
    req.green = g;
    req.blue  = b;
    pending_colors.push_back(req);
    requested_keys.push_back({r[15:11], g[15:11], b[15:11]});
  endtask

  // driver: holds a stalled item, otherwise idles in bursts or sends the next one
  always @(posedge clk) begin
    color_request_t req;
    if (!rst_n) begin
      in_valid     <= 1'b0;
      gap_left     <= 0;
      calm_left    <= 0;
      idle_allowed <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_answers.push_back(map_color(in_red, in_green, in_blue));
      end
      // occasional windows with no idling on either side
      if (calm_left != 0) begin
        calm_left <= calm_left - 1;
      end else if ($urandom_range(0, 299) == 0) begin
        calm_left <= $urandom_range(40, 150);
      end
      // the tail of the run goes without idling
      idle_allowed <= (calm_left == 0) && (pending_colors.size() > 100);
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_colors.size() != 0 && idle_allowed &&
                     $urandom_range(0, 7) == 0) begin
          // burst of idle cycles starting with this one; gap_left holds the rest
          gap_left <= $urandom_range(0, 11);
          in_valid <= 1'b0;
        end else if (pending_colors.size() != 0) begin
          req      = pending_colors.pop_front();
          in_valid <= 1'b1;
          in_red   <= req.red;
          in_green <= req.green;
          in_blue  <= req.blue;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each taken answer against the oldest expectation, stalls in bursts
  always @(posedge clk) begin
    color_result_t want;
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_answers.size() == 0) begin
          $error("answer with nothing expected: color_index %0d", out_color_index);
          mismatch_count++;
        end else begin
          want = expected_answers.pop_front();
          answered_count++;
          if (out_color_index !== want.color_index) begin
            $error("color_index expected %0d got %0d", want.color_index, out_color_index);
            mismatch_count++;
          end
          if (out_no_color !== want.no_color) begin
            $error("no_color expected %0d got %0d", want.no_color, out_no_color);
            mismatch_count++;
          end
          if (out_palette_write !== want.palette_write) begin
            $error("palette_write expected %0d got %0d", want.palette_write,
                   out_palette_write);
            mismatch_count++;
          end
          if (out_palette_red !== want.palette_red) begin
            $error("palette_red expected %0d got %0d", want.palette_red, out_palette_red);
            mismatch_count++;
          end
          if (out_palette_green !== want.palette_green) begin
            $error("palette_green expected %0d got %0d", want.palette_green,
                   out_palette_green);
            mismatch_count++;
          end
          if (out_palette_blue !== want.palette_blue) begin
            $error("palette_blue expected %0d got %0d", want.palette_blue,
                   out_palette_blue);
            mismatch_count++;
          end
        end
      end
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_stall  <= 1'b1;
      end else if (idle_allowed && $urandom_range(0, 5) == 0) begin
        stall_left <= $urandom_range(0, 11);
        out_stall  <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // stimulus, reset and end of run
  initial begin
    logic [KEY_W-1:0] k;
    int               pick;
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      shadow_key[i]   = '0;
      shadow_index[i] = '0;
    end
    shadow_next_free = NFREE_W'(FIRST_DYNAMIC_INDEX);

    // black, white and mixed cube colors
    queue_color(16'h0000, 16'h0000, 16'h0000);
    queue_color(16'hFFFF, 16'hFFFF, 16'hFFFF);
    queue_color({5'd10, 11'h7FF}, {5'd21, 11'h000}, {5'd31, 11'h3A5});
    queue_color({5'd21, 11'h7FF}, {5'd0, 11'h7FF}, {5'd10, 11'h000});
    // just off the cube, then the same key with other low bits: a hit
    queue_color(16'h0800, 16'h0000, 16'h0000);
    queue_color(16'h0FFF, 16'h07FF, 16'h0400);
    // near white, all low bits set, then hit again with low bits clear
    queue_color(16'hF7FF, 16'hFFFF, 16'hFFFF);
    queue_color(16'hF000, 16'hF800, 16'hF800);
    // two channels on the cube, one off
    queue_color(16'h0000, {5'd10, 11'h000}, {5'd5, 11'h7FF});
    // keys 292, 585, 878 share the last slot: the chain wraps to slots 0 and 1
    queue_color(16'h0000, spread(5'd9), spread(5'd4));
    queue_color(16'h0000, spread(5'd18), spread(5'd9));
    queue_color(16'h0000, spread(5'd27), spread(5'd14));
    // key 293 starts at slot 0 and has to step over the wrapped entries
    queue_color(16'h0000, spread(5'd9), spread(5'd5));
    // hits in the chain, the first two only after probing through the wrap, then key 1024
    queue_color(spread(5'd0), spread(5'd18), spread(5'd9));
    queue_color(spread(5'd0), spread(5'd27), spread(5'd14));
    queue_color(spread(5'd0), spread(5'd9), spread(5'd5));
    queue_color(spread(5'd0), spread(5'd9), spread(5'd4));
    queue_color(spread(5'd1), spread(5'd0), spread(5'd0));

    // random mix: cube colors, repeats of earlier keys, fresh colors; fresh
    // colors fill all 192 dynamic indices, so the palette-full answer follows
    for (int n = 0; n < 880; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
        queue_color(spread(cube_levels[$urandom_range(0, 3)]),
                    spread(cube_levels[$urandom_range(0, 3)]),
                    spread(cube_levels[$urandom_range(0, 3)]));
      end else if (pick < 55) begin
        k = requested_keys[$urandom_range(0, requested_keys.size() - 1)];
        queue_color(spread(k[14:10]), spread(k[9:5]), spread(k[4:0]));
      end else begin
        queue_color(16'($urandom), 16'($urandom), 16'($urandom));
      end
    end
    total_items = pending_colors.size();

    // reset once; the block then clears its table before taking items
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // every queued item has to come back as a checked answer
    while (answered_count < total_items) @(posedge clk);
    // a little longer to catch stray answers
    repeat (40) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // hang guard, far beyond the slowest correct run
  initial begin
    #20_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

/* rgb_palette_index_allocator.f */
src/rgbpal_pkg.sv
src/rgbpal_ram.sv
src/rgbpal_front.sv
src/rgbpal_fifo.sv
src/rgbpal_back.sv
src/rgb_palette_index_allocator.sv
dv/rgb_palette_index_allocator_tb.sv
